[rtl/bsva_pkg.sv]
// ----------------------------------------------------------------------------
// Balance state vector assembler package
// Shared widths, item kinds, register indexes, result type and the
// elaboration-time builder for the arcsine table.
// ----------------------------------------------------------------------------
package bsva_pkg;

    localparam int ASIN_BITS    = 10;
    localparam int OP_W         = 2;
    localparam int QUAT_W       = 16;
    localparam int DATA_W       = 32;
    localparam int PITCH_W      = 18;
    localparam int GAIN_W       = 31;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int CORDIC_STEPS = 20;
    localparam longint PITCH_LIMIT = 102944;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    localparam logic [GAIN_W-1:0]        FILTER_GAIN_RST     = 31'd145766090;
    localparam logic signed [DATA_W-1:0] FILTER_FEEDBACK_RST = -32'sd782209644;

    typedef enum logic [OP_W-1:0] {
        OP_INERTIAL = 2'd0,
        OP_SPEED    = 2'd1,
        OP_TICK     = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_GAIN     = 1'b0,
        CFG_FILTER_FEEDBACK = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [DATA_W-1:0]  speed_raw;
        logic signed [DATA_W-1:0]  speed_filtered;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [DATA_W-1:0]  pitch_rate;
    } t_result;

    // atan(2^-k) in Q2.30
    localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
        64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6, 64'sh03FEAB76,
        64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55, 64'sh003FFFEA, 64'sh001FFFFD,
        64'sh000FFFFF, 64'sh0007FFFF, 64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF,
        64'sh00007FFF, 64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF
    };

    // Integer square root, evaluated at elaboration only.
    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Table entry idx: asin(idx / (2^bits - 1)) in Q2.16, by CORDIC vectoring.
    function automatic logic [PITCH_W-1:0] asin_entry(input int unsigned idx,
                                                      input int unsigned bits);
        longint m;
        longint i;
        longint x;
        longint y;
        longint z;
        longint q;
        longint nx;
        longint ny;
        m = (64'sd1 <<< bits) - 64'sd1;
        i = longint'(idx);
        if (i == 0 || m == 0) begin
            return '0;
        end
        if (i > m) begin
            i = m;
        end
        x = longint'(isqrt64(longint'((m * m - i * i) <<< 32)));
        y = i <<< 16;
        z = 64'sd0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (y >= 0) begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                z  = z + ATAN_Q30[k];
            end else begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                z  = z - ATAN_Q30[k];
            end
            x = nx;
            y = ny;
        end
        q = (z + 64'sd8192) >>> 14;
        if (q < 0) begin
            q = 0;
        end
        if (q > PITCH_LIMIT) begin
            q = PITCH_LIMIT;
        end
        return q[PITCH_W-1:0];
    endfunction

endpackage

[rtl/bsva_item_if.sv]
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one inertial, wheel-speed or tick item.
// ----------------------------------------------------------------------------
interface bsva_item_if;
    logic                                  valid;
    logic                                  ready;
    logic [bsva_pkg::OP_W-1:0]             operation;
    logic signed [bsva_pkg::QUAT_W-1:0]    quat_x;
    logic signed [bsva_pkg::QUAT_W-1:0]    quat_y;
    logic signed [bsva_pkg::QUAT_W-1:0]    quat_z;
    logic signed [bsva_pkg::QUAT_W-1:0]    quat_w;
    logic signed [bsva_pkg::DATA_W-1:0]    pitch_rate_in;
    logic signed [bsva_pkg::DATA_W-1:0]    speed_in;

    modport source (
        output valid, operation, quat_x, quat_y, quat_z, quat_w, pitch_rate_in, speed_in,
        input  ready
    );
    modport sink (
        input  valid, operation, quat_x, quat_y, quat_z, quat_w, pitch_rate_in, speed_in,
        output ready
    );
endinterface

[rtl/bsva_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one assembled state vector.
// ----------------------------------------------------------------------------
interface bsva_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bsva_pkg::DATA_W-1:0]    speed_raw;
    logic signed [bsva_pkg::DATA_W-1:0]    speed_filtered;
    logic signed [bsva_pkg::PITCH_W-1:0]   pitch;
    logic signed [bsva_pkg::DATA_W-1:0]    pitch_rate;

    modport source (
        output valid, speed_raw, speed_filtered, pitch, pitch_rate,
        input  ready
    );
    modport sink (
        input  valid, speed_raw, speed_filtered, pitch, pitch_rate,
        output ready
    );
endinterface

[rtl/bsva_asin_rom.sv]
// ----------------------------------------------------------------------------
// Arcsine table
// Constant table of asin(i/M) in Q2.16 with a registered read port.
// ----------------------------------------------------------------------------
module bsva_asin_rom #(
    parameter int AsinBits = bsva_pkg::ASIN_BITS
) (
    input  logic                              i_clk,
    input  logic [AsinBits-1:0]               i_addr,
    output logic [bsva_pkg::PITCH_W-1:0]      o_data
);

    localparam int Depth = 1 << AsinBits;

    logic [bsva_pkg::PITCH_W-1:0] w_table [Depth];
    logic [bsva_pkg::PITCH_W-1:0] r_data;

    for (genvar g = 0; g < Depth; g++) begin : g_entry
        assign w_table[g] = bsva_pkg::asin_entry(g, AsinBits);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_table[i_addr];
    end

    assign o_data = r_data;

endmodule

[rtl/balance_state_vector_assembler.sv]
// ----------------------------------------------------------------------------
// Balance state vector assembler
// Keeps pitch (from quaternion), pitch rate, raw and low-pass filtered wheel
// speed, and emits them as one state vector on each tick item once both an inertial and a speed item have arrived.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Handshake      Carries
//  ---------  ---  -------------  ---------------------------------------------
//  i_item     in   valid/ready    operation, quaternion, pitch rate, speed
//  o_result   out  valid/ready    speed_raw, speed_filtered, pitch, pitch_rate
//  i_cfg_*    in   write enable   filter_gain (index 0), filter_feedback (1)
//
//  One item per cycle while ready is high. An item passes an input stage, a
//  product stage and a table stage (registered arcsine read); state updates
//  from the table stage registers, and a tick's result enters the output queue
//  on that same edge; the queue holds it until the sink takes it.
//  Ready drops only when queued results plus ticks in flight would fill the
//  8-entry output queue; the queue decouples a stalled sink from the input.
//  Synchronous active-low reset returns the filter coefficients to their
//  defaults and clears state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module balance_state_vector_assembler #(
    parameter int AsinBits = bsva_pkg::ASIN_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    bsva_item_if.sink                             i_item,
    bsva_result_if.source                         o_result,
    input  logic                                  i_cfg_we,
    input  logic [bsva_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bsva_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int DW     = bsva_pkg::DATA_W;
    localparam int QW     = bsva_pkg::QUAT_W;
    localparam int PW     = bsva_pkg::PITCH_W;
    localparam int CntW   = bsva_pkg::FIFO_AW + 1;
    localparam int MagW   = 29;
    localparam int ProdW  = MagW + AsinBits;
    localparam logic signed [2*DW+1:0] AccHi =
        (66'sd1 <<< 61) - (66'sd1 <<< 29);
    localparam logic signed [2*DW+1:0] AccLo =
        -(66'sd1 <<< 61) - (66'sd1 <<< 29);
    localparam logic signed [2*DW+1:0] AccHalf = 66'sd1 <<< 29;
    localparam logic signed [2*DW+1:0] OutMax  = 66'sd2147483647;
    localparam logic signed [2*DW+1:0] OutMin  = -66'sd2147483648;
    localparam logic signed [2*DW+1:0] OutMaxPre = OutMax;
    localparam logic signed [33:0] SLim = 34'sd268435456;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bsva_pkg::GAIN_W-1:0] r_gain;
    logic signed [DW-1:0]        r_feedback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= bsva_pkg::FILTER_GAIN_RST;
            r_feedback <= bsva_pkg::FILTER_FEEDBACK_RST;
        end else if (i_cfg_we) begin
            case (bsva_pkg::t_cfg_reg'(i_cfg_index))
                bsva_pkg::CFG_FILTER_GAIN: begin
                    r_gain <= i_cfg_data[bsva_pkg::GAIN_W-1:0];
                end
                bsva_pkg::CFG_FILTER_FEEDBACK: begin
                    r_feedback <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline stage registers
    // ------------------------------------------------------------------
    logic                   w_accept;
    logic                   r_s1_valid;
    logic [1:0]             r_s1_op;
    logic signed [QW-1:0]   r_s1_qx, r_s1_qy, r_s1_qz, r_s1_qw;
    logic signed [DW-1:0]   r_s1_rate, r_s1_speed;

    logic                   r_s2_valid;
    logic [1:0]             r_s2_op;
    logic signed [DW-1:0]   r_s2_wy, r_s2_zx;
    logic signed [DW-1:0]   r_s2_rate, r_s2_speed;

    logic                   r_s3_valid;
    logic [1:0]             r_s3_op;
    logic                   r_s3_neg;
    logic signed [DW-1:0]   r_s3_rate, r_s3_speed;
    logic [PW-1:0]          w_s3_asin;

    assign w_accept = i_item.valid && i_item.ready;

    // Valid bits advance every cycle; the pipeline never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: form s = 2(wy - zx), clamp, and index the table
    // ------------------------------------------------------------------
    logic signed [32:0]     w_diff;
    logic signed [33:0]     w_s;
    logic signed [33:0]     w_s_clamped;
    logic                   w_neg;
    logic signed [33:0]     w_s_abs;
    logic [MagW-1:0]        w_mag;
    logic [ProdW-1:0]       w_prod;
    logic [ProdW-1:0]       w_round;
    logic [AsinBits-1:0]    w_idx;

    always_comb begin
        w_diff = {r_s2_wy[DW-1], r_s2_wy} - {r_s2_zx[DW-1], r_s2_zx};
        w_s    = {w_diff, 1'b0};
        if (w_s > SLim) begin
            w_s_clamped = SLim;
        end else if (w_s < -SLim) begin
            w_s_clamped = -SLim;
        end else begin
            w_s_clamped = w_s;
        end
        w_neg   = w_s_clamped[33];
        w_s_abs = w_neg ? -w_s_clamped : w_s_clamped;
        w_mag   = w_s_abs[MagW-1:0];
        // mag * (2^bits - 1), then round at bit 28
        w_prod  = {w_mag, AsinBits'(0)} - ProdW'(w_mag);
        w_round = w_prod + (ProdW'(1) << 27);
        w_idx   = w_round[27+AsinBits:28];
    end

    bsva_asin_rom #(
        .AsinBits (AsinBits)
    ) u_asin_rom (
        .i_clk  (i_clk),
        .i_addr (w_idx),
        .o_data (w_s3_asin)
    );

    // Payload of the stages: no reset needed.
    always_ff @(posedge i_clk) begin
        r_s1_op    <= i_item.operation;
        r_s1_qx    <= i_item.quat_x;
        r_s1_qy    <= i_item.quat_y;
        r_s1_qz    <= i_item.quat_z;
        r_s1_qw    <= i_item.quat_w;
        r_s1_rate  <= i_item.pitch_rate_in;
        r_s1_speed <= i_item.speed_in;

        r_s2_op    <= r_s1_op;
        r_s2_wy    <= r_s1_qw * r_s1_qy;
        r_s2_zx    <= r_s1_qz * r_s1_qx;
        r_s2_rate  <= r_s1_rate;
        r_s2_speed <= r_s1_speed;

        r_s3_op    <= r_s2_op;
        r_s3_neg   <= w_neg;
        r_s3_rate  <= r_s2_rate;
        r_s3_speed <= r_s2_speed;
    end

    // ------------------------------------------------------------------
    // Stage 3: Tustin low-pass, y = b(x + x_prev) - a1*y_prev
    // ------------------------------------------------------------------
    logic signed [DW-1:0]      r_last_speed;
    logic signed [DW-1:0]      r_filtered;
    logic signed [PW-1:0]      r_last_pitch;
    logic signed [DW-1:0]      r_last_rate;
    logic                      r_inertial_seen;
    logic                      r_speed_seen;

    logic signed [DW:0]        w_sum;
    logic signed [2*DW:0]      w_p1;
    logic signed [2*DW-1:0]    w_p2;
    logic signed [2*DW+1:0]    w_acc;
    logic signed [2*DW+1:0]    w_shifted;
    logic signed [DW-1:0]      w_filter_out;
    logic signed [PW-1:0]      w_pitch;

    always_comb begin
        w_sum     = {r_s3_speed[DW-1], r_s3_speed} + {r_last_speed[DW-1], r_last_speed};
        w_p1      = $signed({1'b0, r_gain}) * w_sum;
        w_p2      = r_feedback * r_filtered;
        w_acc     = {w_p1[2*DW], w_p1} - {{2{w_p2[2*DW-1]}}, w_p2};
        w_shifted = (w_acc + AccHalf) >>> 30;
        // saturate at the rounded-range bounds
        if (w_acc >= AccHi) begin
            w_filter_out = OutMaxPre[DW-1:0];
        end else if (w_acc < AccLo) begin
            w_filter_out = OutMin[DW-1:0];
        end else begin
            w_filter_out = w_shifted[DW-1:0];
        end
        w_pitch = r_s3_neg ? -$signed(w_s3_asin) : $signed(w_s3_asin);
    end

    // ------------------------------------------------------------------
    // Stage 3: state update and result push
    // ------------------------------------------------------------------
    logic w_push;
    logic w_pop;

    assign w_push = r_s3_valid && (r_s3_op == bsva_pkg::OP_TICK)
                    && r_inertial_seen && r_speed_seen;
    assign w_pop  = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_speed    <= '0;
            r_filtered      <= '0;
            r_last_pitch    <= '0;
            r_last_rate     <= '0;
            r_inertial_seen <= 1'b0;
            r_speed_seen    <= 1'b0;
        end else if (r_s3_valid) begin
            case (r_s3_op)
                bsva_pkg::OP_INERTIAL: begin
                    r_last_pitch    <= w_pitch;
                    r_last_rate     <= r_s3_rate;
                    r_inertial_seen <= 1'b1;
                end
                bsva_pkg::OP_SPEED: begin
                    r_last_speed <= r_s3_speed;
                    r_filtered   <= w_filter_out;
                    r_speed_seen <= 1'b1;
                end
                default: begin
                    // ticks only read state; an unknown kind is dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    bsva_pkg::t_result           r_fifo [bsva_pkg::FIFO_DEPTH];
    bsva_pkg::t_result           w_entry;
    logic [bsva_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [bsva_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [CntW-1:0]             r_count;
    logic [CntW-1:0]             n_count;
    logic [1:0]                  w_pending;
    logic [CntW-1:0]             w_used;

    assign w_entry.speed_raw      = r_last_speed;
    assign w_entry.speed_filtered = r_filtered;
    assign w_entry.pitch          = r_last_pitch;
    assign w_entry.pitch_rate     = r_last_rate;

    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + CntW'(1);
            2'b01:   n_count = r_count - CntW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + bsva_pkg::FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + bsva_pkg::FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_entry;
        end
    end

    // Reserve a queue slot for every tick still in the pipeline.
    assign w_pending = 2'(r_s1_valid && (r_s1_op == bsva_pkg::OP_TICK))
                     + 2'(r_s2_valid && (r_s2_op == bsva_pkg::OP_TICK))
                     + 2'(r_s3_valid && (r_s3_op == bsva_pkg::OP_TICK));
    assign w_used    = r_count + CntW'(w_pending);

    assign i_item.ready = (w_used < CntW'(bsva_pkg::FIFO_DEPTH));

    assign o_result.valid          = (r_count != '0);
    assign o_result.speed_raw      = r_fifo[r_rd_ptr].speed_raw;
    assign o_result.speed_filtered = r_fifo[r_rd_ptr].speed_filtered;
    assign o_result.pitch          = r_fifo[r_rd_ptr].pitch;
    assign o_result.pitch_rate     = r_fifo[r_rd_ptr].pitch_rate;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= CntW'(bsva_pkg::FIFO_DEPTH))
        else $error("output queue reservation exceeds queue depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |-> (r_count < CntW'(bsva_pkg::FIFO_DEPTH)))
        else $error("push into a full output queue");

    a_result_after_sensors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (r_inertial_seen && r_speed_seen))
        else $error("result present before both sensor kinds arrived");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("queue count did not advance on push");
`endif

endmodule
